// ===== rtl/lcdns_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types and constants of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

   // request codes
   localparam logic [1:0] CMD_INIT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_CURSOR = 2'd2;
   localparam logic [1:0] CMD_WRITE  = 2'd3;

   // controller opcodes and nibbles
   localparam logic [7:0] OP_FUNCSET  = 8'h28;
   localparam logic [7:0] OP_DISPOFF  = 8'h08;
   localparam logic [7:0] OP_CLEAR    = 8'h01;
   localparam logic [7:0] OP_ENTRY    = 8'h06;
   localparam logic [7:0] OP_DISPON   = 8'h0C;
   localparam logic [3:0] WAKE_NIB    = 4'h3;
   localparam logic [3:0] FOURBIT_NIB = 4'h2;

   // waits
   localparam logic [5:0] POWERUP_MS   = 6'd50;
   localparam logic [2:0] HOLD_NONE    = 3'd0;
   localparam logic [2:0] HOLD_WAKE    = 3'd1;
   localparam logic [2:0] HOLD_FIRST   = 3'd5;
   localparam logic [2:0] HOLD_CLEAR   = 3'd3;

   // initialise runs over this many transfers
   localparam int unsigned INIT_STEPS = 14;
   localparam logic [3:0]  INIT_LAST  = 4'(INIT_STEPS - 1);

   // one job for the back end: a full init run, or one byte as two nibbles
   typedef struct packed {
      logic       init;
      logic [7:0] data;
      logic       rs;
      logic [2:0] hold_lo;
   } job_type;

   typedef struct packed {
      logic [3:0] nibble;
      logic [5:0] lead;
      logic [2:0] hold;
   } xfer_type;

   // transfer table of the initialise run
   function automatic xfer_type init_xfer(input logic [3:0] step);
      xfer_type x;
      x = '{nibble: 4'h0, lead: 6'd0, hold: HOLD_NONE};
      case (step)
         4'd0:  x = '{nibble: WAKE_NIB, lead: POWERUP_MS, hold: HOLD_FIRST};
         4'd1:  x = '{nibble: WAKE_NIB, lead: 6'd0, hold: HOLD_WAKE};
         4'd2:  x = '{nibble: WAKE_NIB, lead: 6'd0, hold: HOLD_WAKE};
         4'd3:  x = '{nibble: FOURBIT_NIB, lead: 6'd0, hold: HOLD_WAKE};
         4'd4:  x.nibble = OP_FUNCSET[7:4];
         4'd5:  x.nibble = OP_FUNCSET[3:0];
         4'd6:  x.nibble = OP_DISPOFF[7:4];
         4'd7:  x.nibble = OP_DISPOFF[3:0];
         4'd8:  x.nibble = OP_CLEAR[7:4];
         4'd9:  x = '{nibble: OP_CLEAR[3:0], lead: 6'd0, hold: HOLD_CLEAR};
         4'd10: x.nibble = OP_ENTRY[7:4];
         4'd11: x.nibble = OP_ENTRY[3:0];
         4'd12: x.nibble = OP_DISPON[7:4];
         4'd13: x.nibble = OP_DISPON[3:0];
         default: x = '{nibble: 4'h0, lead: 6'd0, hold: HOLD_NONE};
      endcase
      return x;
   endfunction

endpackage

// ===== rtl/lcdns_front.sv =====
// ----------------------------------------------------------------------------
// lcdns_front
// Classifies a request into a job: an initialise run or one byte to send.
// ----------------------------------------------------------------------------
module lcdns_front (
   input  logic [1:0]            req_cmd,
   input  logic [7:0]            req_char_code,
   input  logic [5:0]            req_column,
   input  logic                  req_line,
   output lcdns_pkg::job_type    job
);

   always_comb begin
      job = '{init: 1'b0, data: 8'h00, rs: 1'b0, hold_lo: lcdns_pkg::HOLD_NONE};
      unique case (req_cmd)
         lcdns_pkg::CMD_INIT: begin
            job.init = 1'b1;
         end
         lcdns_pkg::CMD_CLEAR: begin
            job.data    = lcdns_pkg::OP_CLEAR;
            job.hold_lo = lcdns_pkg::HOLD_CLEAR;
         end
         lcdns_pkg::CMD_CURSOR: begin
            // column below 64 so line 1 offset is just bit 6
            job.data = {1'b1, req_line, req_column};
         end
         lcdns_pkg::CMD_WRITE: begin
            job.data = req_char_code;
            job.rs   = 1'b1;
         end
         default: begin
            job.init = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/lcdns_job_queue.sv =====
// ----------------------------------------------------------------------------
// lcdns_job_queue
// Short queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module lcdns_job_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  lcdns_pkg::job_type   wr_job,
   output logic                 full,
   input  logic                 rd_en,
   output lcdns_pkg::job_type   rd_job,
   output logic                 not_empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   lcdns_pkg::job_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ===== rtl/lcdns_back.sv =====
// ----------------------------------------------------------------------------
// lcdns_back
// Walks the head job nibble by nibble into the result register.
// ----------------------------------------------------------------------------
module lcdns_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  lcdns_pkg::job_type   job,
   output logic                 job_done,
   output logic                 empty,
   input  logic                 pop,
   output logic [3:0]           rsp_nibble,
   output logic                 rsp_reg_select,
   output logic [5:0]           rsp_lead_wait_ms,
   output logic [2:0]           rsp_hold_ms,
   output logic                 rsp_last
);

   logic [3:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] nibble_ff;
   logic       rs_ff;
   logic [5:0] lead_ff;
   logic [2:0] hold_ff;
   logic       last_ff;

   logic                 load;
   logic                 step_last;
   lcdns_pkg::xfer_type  xfer;

   assign load = job_valid && (!out_valid_ff || pop);

   always_comb begin
      if (job.init) begin
         xfer      = lcdns_pkg::init_xfer(step_ff);
         step_last = (step_ff == lcdns_pkg::INIT_LAST);
      end else begin
         step_last = step_ff[0];
         xfer.lead = 6'd0;
         if (step_ff[0]) begin
            xfer.nibble = job.data[3:0];
            xfer.hold   = job.hold_lo;
         end else begin
            xfer.nibble = job.data[7:4];
            xfer.hold   = lcdns_pkg::HOLD_NONE;
         end
      end
      job_done     = load && step_last;
      step_in      = load ? (step_last ? 4'd0 : step_ff + 4'd1) : step_ff;
      out_valid_in = load || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nibble_ff <= xfer.nibble;
         rs_ff     <= job.rs;
         lead_ff   <= xfer.lead;
         hold_ff   <= xfer.hold;
         last_ff   <= step_last;
      end
   end

   assign empty            = !out_valid_ff;
   assign rsp_nibble       = nibble_ff;
   assign rsp_reg_select   = rs_ff;
   assign rsp_lead_wait_ms = lead_ff;
   assign rsp_hold_ms      = hold_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/char_lcd_nibble_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// HD44780-style 4-bit bus sequencer: requests in, nibble transfers out.
// ----------------------------------------------------------------------------
// The first nibble of a request passes the job queue and then the result register.
// One nibble per cycle while the result side pops; a request is sent as two nibbles
// (initialise as 14 transfers) through the single result register.
// Requests queue up (QUEUE_DEPTH jobs) while the back end is busy.
// Reset: synchronous; empties the job queue and result register, step count 0.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [5:0]  req_column,
   input  logic        req_line,
   // result side
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_nibble,
   output logic        rsp_reg_select,
   output logic [5:0]  rsp_lead_wait_ms,
   output logic [2:0]  rsp_hold_ms,
   output logic        rsp_last
);

   lcdns_pkg::job_type new_job;
   lcdns_pkg::job_type head_job;
   logic               head_valid;
   logic               head_done;
   logic               push_ok;

   // accept only when the queue has room
   assign push_ok = push && !full;

   // Front end: classify the request into one job word.
   lcdns_front u_front (
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_column    (req_column),
      .req_line      (req_line),
      .job           (new_job)
   );

   // Hold jobs so the request side need not wait on a stalled result side until the queue is full.
   lcdns_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (push_ok),
      .wr_job    (new_job),
      .full      (full),
      .rd_en     (head_done),
      .rd_job    (head_job),
      .not_empty (head_valid)
   );

   // Back end: advance through the head job's nibbles, drop it after the last.
   lcdns_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (head_valid),
      .job              (head_job),
      .job_done         (head_done),
      .empty            (empty),
      .pop              (pop),
      .rsp_nibble       (rsp_nibble),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_lead_wait_ms (rsp_lead_wait_ms),
      .rsp_hold_ms      (rsp_hold_ms),
      .rsp_last         (rsp_last)
   );

   // a power-up wait only ever precedes the first wake nibble
   a_lead_only_on_wake: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_lead_wait_ms != 6'd0) |->
         (rsp_nibble == lcdns_pkg::WAKE_NIB && !rsp_reg_select && !rsp_last))
      else $error("lead wait on a transfer other than the first wake nibble");

   // data transfers never carry waits
   a_data_no_wait: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_reg_select) |->
         (rsp_lead_wait_ms == 6'd0 && rsp_hold_ms == lcdns_pkg::HOLD_NONE))
      else $error("data transfer with a wait attached");

   // a job is retired only while one is present
   a_done_needs_job: assert property (@(posedge clock) disable iff (reset)
      head_done |-> head_valid)
      else $error("job retired from an empty queue");

   // a retired job always leaves its final transfer in the result register
   a_done_sets_last: assert property (@(posedge clock) disable iff (reset)
      head_done |=> (!empty && rsp_last))
      else $error("job retired without a final transfer");

endmodule
